@@ design/tgi_pkg.sv @@
`timescale 1ns / 1ps
package tgi_pkg;

	localparam int DEF_GRID_SIDE  = 32;
	localparam int DEF_TIME_STEPS = 32;
	localparam int DATA_W         = 32;
	localparam int FRAC_W         = 16;
	localparam int WIDX_W         = 5;
	localparam int CFG_IDX_W      = 2;
	localparam int BANKS          = 8;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN        = 2'd0,
		REG_INV_SPACING   = 2'd1,
		REG_INV_TIME_STEP = 2'd2
	} cfg_reg_t;

	// Parity of the low corner and top-edge clamp on each axis.
	typedef struct packed {
		logic px;
		logic py;
		logic pt;
		logic cx;
		logic cy;
		logic ct;
	} axis_sel_t;

endpackage

@@ design/tgi_in_if.sv @@
`timescale 1ns / 1ps
interface tgi_in_if;
	import tgi_pkg::*;

	logic              valid;
	logic              ready;
	logic              command;
	logic [DATA_W-1:0] x_coord;
	logic [DATA_W-1:0] y_coord;
	logic [DATA_W-1:0] t_coord;
	logic [WIDX_W-1:0] write_x_index;
	logic [WIDX_W-1:0] write_y_index;
	logic [WIDX_W-1:0] write_t_index;
	logic [DATA_W-1:0] write_value;

	modport source (
		output valid, command, x_coord, y_coord, t_coord,
		output write_x_index, write_y_index, write_t_index, write_value,
		input  ready
	);
	modport sink (
		input  valid, command, x_coord, y_coord, t_coord,
		input  write_x_index, write_y_index, write_t_index, write_value,
		output ready
	);
endinterface

@@ design/tgi_out_if.sv @@
`timescale 1ns / 1ps
interface tgi_out_if;
	import tgi_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] value;
	logic              out_of_range;

	modport source (output valid, value, out_of_range, input ready);
	modport sink (input valid, value, out_of_range, output ready);
endinterface

@@ design/trilinear_grid_interpolator_unit.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Items
// in_item   in   command, x/y/t coordinates, write indices and write value
// out_item  out  value, out_of_range (one per query, none per write)
// cfg_*     in   origin, inv_spacing, inv_time_step
//
// One item is taken every cycle while no stall reaches the input; a query's
// result passes the locate stages, which find the cell, a grid stage that reads
// eight parity banks, and three lerp units of three stages each along t, y and x.
// Reset clears the valid bits and the origin and sets both inverse steps to 1.0; the grid is not cleared.
// A stall at the output holds each stage only while the stage after it is full.
module trilinear_grid_interpolator_unit #(
	parameter int GRID_SIDE  = tgi_pkg::DEF_GRID_SIDE,
	parameter int TIME_STEPS = tgi_pkg::DEF_TIME_STEPS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tgi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tgi_pkg::DATA_W-1:0]    cfg_data,
	tgi_in_if.sink                        in_item,
	tgi_out_if.source                     out_item
);
	import tgi_pkg::*;

	localparam int XIW = $clog2(GRID_SIDE);
	localparam int TIW = $clog2(TIME_STEPS);
	localparam int XHW = (XIW > 1) ? XIW - 1 : 1;
	localparam int THW = (TIW > 1) ? TIW - 1 : 1;
	localparam int AW  = 2 * XHW + THW;

	logic [DATA_W-1:0] origin_q, inv_spacing_q, inv_time_step_q;

	logic              en4, en5, en_y, en_x;
	logic              v_s3, cmd_s3, oor_s3, wok_s3;
	logic [AW-1:0]     addr_s3 [BANKS];
	axis_sel_t         sel_s3, sel_s4;
	logic [FRAC_W-1:0] rx_s3, ry_s3, rt_s3, rx_s4, ry_s4, rt_s4;
	logic [2:0]        wbank_s3;
	logic [AW-1:0]     waddr_s3;
	logic [DATA_W-1:0] wval_s3;
	logic              v_s4, oor_s4;
	logic [DATA_W-1:0] rd_s4 [BANKS];

	logic [DATA_W-1:0] ta [4];
	logic [DATA_W-1:0] tb [4];
	logic [DATA_W-1:0] tu [4];
	logic [DATA_W-1:0] ya [2];
	logic [DATA_W-1:0] yb [2];
	logic [DATA_W-1:0] yu [2];
	logic [DATA_W-1:0] xa [1];
	logic [DATA_W-1:0] xb [1];
	logic [DATA_W-1:0] xu [1];
	logic              tv, yv;
	logic [2*FRAC_W:0] t_side;
	logic [2*FRAC_W:0] t_side_o;
	logic [FRAC_W:0]   y_side;
	logic [FRAC_W:0]   y_side_o;
	logic [0:0]        x_side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q        <= '0;
			inv_spacing_q   <= DATA_W'(1 << FRAC_W);
			inv_time_step_q <= DATA_W'(1 << FRAC_W);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ORIGIN:        origin_q        <= cfg_data;
				REG_INV_SPACING:   inv_spacing_q   <= cfg_data;
				REG_INV_TIME_STEP: inv_time_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tgi_locate #(.GRID_SIDE(GRID_SIDE), .TIME_STEPS(TIME_STEPS), .AW(AW)) u_locate (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_item.valid), .in_en(in_item.ready),
		.command(in_item.command),
		.x_coord(in_item.x_coord), .y_coord(in_item.y_coord), .t_coord(in_item.t_coord),
		.write_x_index(in_item.write_x_index), .write_y_index(in_item.write_y_index),
		.write_t_index(in_item.write_t_index), .write_value(in_item.write_value),
		.origin(origin_q), .inv_spacing(inv_spacing_q), .inv_time_step(inv_time_step_q),
		.out_en(en4), .v_s3(v_s3), .cmd_s3(cmd_s3), .addr_s3(addr_s3), .sel_s3(sel_s3),
		.rx_s3(rx_s3), .ry_s3(ry_s3), .rt_s3(rt_s3), .oor_s3(oor_s3),
		.wbank_s3(wbank_s3), .waddr_s3(waddr_s3), .wval_s3(wval_s3), .wok_s3(wok_s3)
	);

	tgi_grid_mem #(.AW(AW)) u_grid_mem (
		.clk(clk), .arst_n(arst_n), .v_s3(v_s3), .in_en(en4),
		.cmd_s3(cmd_s3), .addr_s3(addr_s3), .sel_s3(sel_s3),
		.rx_s3(rx_s3), .ry_s3(ry_s3), .rt_s3(rt_s3), .oor_s3(oor_s3),
		.wbank_s3(wbank_s3), .waddr_s3(waddr_s3), .wval_s3(wval_s3), .wok_s3(wok_s3),
		.out_en(en5), .v_s4(v_s4), .rd_s4(rd_s4), .sel_s4(sel_s4),
		.rx_s4(rx_s4), .ry_s4(ry_s4), .rt_s4(rt_s4), .oor_s4(oor_s4)
	);

	// Corner pair {i, j}: i picks the x neighbor, j the y neighbor.
	always_comb begin
		logic i, j, bx, by;
		for (int p = 0; p < 4; p++) begin
			i     = p[1];
			j     = p[0];
			bx    = sel_s4.px ^ (i & ~sel_s4.cx);
			by    = sel_s4.py ^ (j & ~sel_s4.cy);
			ta[p] = rd_s4[{bx, by, sel_s4.pt}];
			tb[p] = rd_s4[{bx, by, sel_s4.pt ^ ~sel_s4.ct}];
		end
	end

	assign t_side = {rx_s4, ry_s4, oor_s4};

	tgi_lerp #(.LANES(4), .SW(2 * FRAC_W + 1)) u_lerp_t (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s4), .in_en(en5),
		.a(ta), .b(tb), .r(rt_s4), .side_in(t_side),
		.out_valid(tv), .out_en(en_y), .y(tu), .side_out(t_side_o)
	);

	assign ya[0]  = tu[0];
	assign yb[0]  = tu[1];
	assign ya[1]  = tu[2];
	assign yb[1]  = tu[3];
	assign y_side = {t_side_o[2*FRAC_W:FRAC_W+1], t_side_o[0]};

	tgi_lerp #(.LANES(2), .SW(FRAC_W + 1)) u_lerp_y (
		.clk(clk), .arst_n(arst_n), .in_valid(tv), .in_en(en_y),
		.a(ya), .b(yb), .r(t_side_o[FRAC_W:1]), .side_in(y_side),
		.out_valid(yv), .out_en(en_x), .y(yu), .side_out(y_side_o)
	);

	assign xa[0]  = yu[0];
	assign xb[0]  = yu[1];
	assign x_side = y_side_o[0];

	tgi_lerp #(.LANES(1), .SW(1)) u_lerp_x (
		.clk(clk), .arst_n(arst_n), .in_valid(yv), .in_en(en_x),
		.a(xa), .b(xb), .r(y_side_o[FRAC_W:1]), .side_in(x_side),
		.out_valid(out_item.valid), .out_en(out_item.ready), .y(xu),
		.side_out(out_item.out_of_range)
	);

	assign out_item.value = xu[0];

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_item.valid |-> in_item.ready)
		else $error("input stalled while the output stage is empty");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && cmd_s3 == CMD_WRITE && en4 |=> !v_s4)
		else $error("write item entered the interpolation pipeline");

	a_query_enters: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && cmd_s3 == CMD_QUERY && en4 |=> v_s4)
		else $error("query item lost at the grid read");

endmodule

@@ design/tgi_locate.sv @@
`timescale 1ns / 1ps
module tgi_locate #(
	parameter int GRID_SIDE  = tgi_pkg::DEF_GRID_SIDE,
	parameter int TIME_STEPS = tgi_pkg::DEF_TIME_STEPS,
	parameter int AW         = 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_en,
	input  logic                             command,
	input  logic [tgi_pkg::DATA_W-1:0]       x_coord,
	input  logic [tgi_pkg::DATA_W-1:0]       y_coord,
	input  logic [tgi_pkg::DATA_W-1:0]       t_coord,
	input  logic [tgi_pkg::WIDX_W-1:0]       write_x_index,
	input  logic [tgi_pkg::WIDX_W-1:0]       write_y_index,
	input  logic [tgi_pkg::WIDX_W-1:0]       write_t_index,
	input  logic [tgi_pkg::DATA_W-1:0]       write_value,
	input  logic [tgi_pkg::DATA_W-1:0]       origin,
	input  logic [tgi_pkg::DATA_W-1:0]       inv_spacing,
	input  logic [tgi_pkg::DATA_W-1:0]       inv_time_step,
	input  logic                             out_en,
	output logic                             v_s3,
	output logic                             cmd_s3,
	output logic [AW-1:0]                    addr_s3 [tgi_pkg::BANKS],
	output tgi_pkg::axis_sel_t               sel_s3,
	output logic [tgi_pkg::FRAC_W-1:0]       rx_s3,
	output logic [tgi_pkg::FRAC_W-1:0]       ry_s3,
	output logic [tgi_pkg::FRAC_W-1:0]       rt_s3,
	output logic                             oor_s3,
	output logic [2:0]                       wbank_s3,
	output logic [AW-1:0]                    waddr_s3,
	output logic [tgi_pkg::DATA_W-1:0]       wval_s3,
	output logic                             wok_s3
);
	import tgi_pkg::*;

	localparam int XIW = $clog2(GRID_SIDE);
	localparam int TIW = $clog2(TIME_STEPS);
	localparam int XHW = (XIW > 1) ? XIW - 1 : 1;
	localparam int THW = (TIW > 1) ? TIW - 1 : 1;

	logic en1, en2, en3;
	logic v_s1, v_s2;

	logic                    cmd_s1, cmd_s2;
	logic signed [DATA_W:0]  dx_s1, dy_s1;
	logic [DATA_W-1:0]       t_s1;
	logic [2:0]              wbank_s1, wbank_s2;
	logic [AW-1:0]           waddr_s1, waddr_s2;
	logic [DATA_W-1:0]       wval_s1, wval_s2;
	logic                    wok_s1, wok_s2;

	logic                    neg_s2 [2];
	logic [2*DATA_W-1:0]     pr_s2 [2];
	logic                    negt_s2;
	logic [2*DATA_W-1:0]     prt_s2;

	logic [XIW-1:0]    lo_xy [2];
	logic [XIW:0]      lo1_xy [2];
	logic [XHW-1:0]    hlo_xy [2];
	logic [XHW-1:0]    hnx_xy [2];
	logic [FRAC_W-1:0] fr_xy [2];
	logic              bad_xy [2];
	logic              clamp_xy [2];
	logic [TIW-1:0]    lo_t;
	logic [TIW:0]      lo1_t;
	logic [THW-1:0]    hlo_t, hnx_t;
	logic [FRAC_W-1:0] fr_t;
	logic              bad_t, clamp_t;
	logic [AW-1:0]     addr_d [BANKS];

	assign en3   = ~v_s3 | out_en;
	assign en2   = ~v_s2 | en3;
	assign en1   = ~v_s1 | en2;
	assign in_en = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			cmd_s1   <= command;
			dx_s1    <= $signed({x_coord[DATA_W-1], x_coord}) -
				$signed({origin[DATA_W-1], origin});
			dy_s1    <= $signed({y_coord[DATA_W-1], y_coord}) -
				$signed({origin[DATA_W-1], origin});
			t_s1     <= t_coord;
			wbank_s1 <= {write_x_index[0], write_y_index[0], write_t_index[0]};
			waddr_s1 <= {XHW'(write_x_index >> 1), XHW'(write_y_index >> 1),
				THW'(write_t_index >> 1)};
			wval_s1  <= write_value;
			wok_s1   <= (9'(write_x_index) < 9'(GRID_SIDE)) &&
				(9'(write_y_index) < 9'(GRID_SIDE)) &&
				(9'(write_t_index) < 9'(TIME_STEPS));
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			cmd_s2    <= cmd_s1;
			neg_s2[0] <= dx_s1[DATA_W];
			neg_s2[1] <= dy_s1[DATA_W];
			pr_s2[0]  <= (2*DATA_W)'(dx_s1[DATA_W-1:0]) * (2*DATA_W)'(inv_spacing);
			pr_s2[1]  <= (2*DATA_W)'(dy_s1[DATA_W-1:0]) * (2*DATA_W)'(inv_spacing);
			negt_s2   <= t_s1[DATA_W-1];
			prt_s2    <= (2*DATA_W)'(t_s1) * (2*DATA_W)'(inv_time_step);
			wbank_s2  <= wbank_s1;
			waddr_s2  <= waddr_s1;
			wval_s2   <= wval_s1;
			wok_s2    <= wok_s1;
		end
	end

	always_comb begin
		logic [DATA_W-1:0] ip;
		logic              over;
		for (int a = 0; a < 2; a++) begin
			ip          = pr_s2[a][2*DATA_W-1:DATA_W];
			over        = ip > DATA_W'(GRID_SIDE - 1);
			bad_xy[a]   = neg_s2[a] | over;
			lo_xy[a]    = neg_s2[a] ? '0 : (over ? XIW'(GRID_SIDE - 1) : ip[XIW-1:0]);
			fr_xy[a]    = bad_xy[a] ? '0 : pr_s2[a][DATA_W-1:FRAC_W];
			clamp_xy[a] = lo_xy[a] == XIW'(GRID_SIDE - 1);
			lo1_xy[a]   = {1'b0, lo_xy[a]} + 1'b1;
			hlo_xy[a]   = XHW'(lo_xy[a] >> 1);
			hnx_xy[a]   = XHW'(lo1_xy[a] >> 1);
		end
	end

	always_comb begin
		logic [DATA_W-1:0] ip;
		logic              over;
		ip      = prt_s2[2*DATA_W-1:DATA_W];
		over    = ip > DATA_W'(TIME_STEPS - 1);
		bad_t   = negt_s2 | over;
		lo_t    = negt_s2 ? '0 : (over ? TIW'(TIME_STEPS - 1) : ip[TIW-1:0]);
		fr_t    = bad_t ? '0 : prt_s2[DATA_W-1:FRAC_W];
		clamp_t = lo_t == TIW'(TIME_STEPS - 1);
		lo1_t   = {1'b0, lo_t} + 1'b1;
		hlo_t   = THW'(lo_t >> 1);
		hnx_t   = THW'(lo1_t >> 1);
	end

	// Each bank holds one parity class; it serves either the low or the high neighbor.
	always_comb begin
		logic [2:0] bb;
		for (int b = 0; b < BANKS; b++) begin
			bb = 3'(b);
			addr_d[b] = {(bb[2] == lo_xy[0][0]) ? hlo_xy[0] : hnx_xy[0],
				(bb[1] == lo_xy[1][0]) ? hlo_xy[1] : hnx_xy[1],
				(bb[0] == lo_t[0]) ? hlo_t : hnx_t};
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			cmd_s3    <= cmd_s2;
			addr_s3   <= addr_d;
			sel_s3    <= '{px: lo_xy[0][0], py: lo_xy[1][0], pt: lo_t[0],
				cx: clamp_xy[0], cy: clamp_xy[1], ct: clamp_t};
			rx_s3     <= fr_xy[0];
			ry_s3     <= fr_xy[1];
			rt_s3     <= fr_t;
			oor_s3    <= bad_xy[0] | bad_xy[1] | bad_t;
			wbank_s3  <= wbank_s2;
			waddr_s3  <= waddr_s2;
			wval_s3   <= wval_s2;
			wok_s3    <= wok_s2;
		end
	end

endmodule

@@ design/tgi_grid_mem.sv @@
`timescale 1ns / 1ps
module tgi_grid_mem #(
	parameter int AW = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       v_s3,
	output logic                       in_en,
	input  logic                       cmd_s3,
	input  logic [AW-1:0]              addr_s3 [tgi_pkg::BANKS],
	input  tgi_pkg::axis_sel_t         sel_s3,
	input  logic [tgi_pkg::FRAC_W-1:0] rx_s3,
	input  logic [tgi_pkg::FRAC_W-1:0] ry_s3,
	input  logic [tgi_pkg::FRAC_W-1:0] rt_s3,
	input  logic                       oor_s3,
	input  logic [2:0]                 wbank_s3,
	input  logic [AW-1:0]              waddr_s3,
	input  logic [tgi_pkg::DATA_W-1:0] wval_s3,
	input  logic                       wok_s3,
	input  logic                       out_en,
	output logic                       v_s4,
	output logic [tgi_pkg::DATA_W-1:0] rd_s4 [tgi_pkg::BANKS],
	output tgi_pkg::axis_sel_t         sel_s4,
	output logic [tgi_pkg::FRAC_W-1:0] rx_s4,
	output logic [tgi_pkg::FRAC_W-1:0] ry_s4,
	output logic [tgi_pkg::FRAC_W-1:0] rt_s4,
	output logic                       oor_s4
);
	import tgi_pkg::*;

	logic en4, adv;

	assign en4   = ~v_s4 | out_en;
	assign in_en = en4;
	assign adv   = en4 & v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en4) begin
			v_s4 <= v_s3 && (cmd_s3 == CMD_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sel_s4 <= sel_s3;
			rx_s4  <= rx_s3;
			ry_s4  <= ry_s3;
			rt_s4  <= rt_s3;
			oor_s4 <= oor_s3;
		end
	end

	for (genvar b = 0; b < BANKS; b++) begin : g_bank
		logic [DATA_W-1:0] bank_mem [2**AW];
		logic [DATA_W-1:0] rdata_s4;

		always_ff @(posedge clk) begin
			if (adv) begin
				if (cmd_s3 == CMD_WRITE) begin
					if (wok_s3 && wbank_s3 == 3'(b)) bank_mem[waddr_s3] <= wval_s3;
				end else begin
					rdata_s4 <= bank_mem[addr_s3[b]];
				end
			end
		end

		assign rd_s4[b] = rdata_s4;
	end

endmodule

@@ design/tgi_lerp.sv @@
`timescale 1ns / 1ps
module tgi_lerp #(
	parameter int LANES = 1,
	parameter int SW    = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_en,
	input  logic [tgi_pkg::DATA_W-1:0] a [LANES],
	input  logic [tgi_pkg::DATA_W-1:0] b [LANES],
	input  logic [tgi_pkg::FRAC_W-1:0] r,
	input  logic [SW-1:0]              side_in,
	output logic                       out_valid,
	input  logic                       out_en,
	output logic [tgi_pkg::DATA_W-1:0] y [LANES],
	output logic [SW-1:0]              side_out
);
	import tgi_pkg::*;

	localparam int PW = DATA_W + FRAC_W + 2;

	logic en1, en2, en3;
	logic v_s1, v_s2, v_s3;

	logic [DATA_W-1:0]     a_s1 [LANES];
	logic signed [DATA_W:0] d_s1 [LANES];
	logic [FRAC_W-1:0]     r_s1;
	logic [SW-1:0]         side_s1, side_s2, side_s3;
	logic [DATA_W-1:0]     a_s2 [LANES];
	logic signed [PW-1:0]  p_s2 [LANES];
	logic [DATA_W-1:0]     y_s3 [LANES];

	assign en3   = ~v_s3 | out_en;
	assign en2   = ~v_s2 | en3;
	assign en1   = ~v_s1 | en2;
	assign in_en = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int l = 0; l < LANES; l++) begin
				a_s1[l] <= a[l];
				d_s1[l] <= $signed({b[l][DATA_W-1], b[l]}) - $signed({a[l][DATA_W-1], a[l]});
			end
			r_s1    <= r;
			side_s1 <= side_in;
		end
		if (en2) begin
			for (int l = 0; l < LANES; l++) begin
				a_s2[l] <= a_s1[l];
				p_s2[l] <= d_s1[l] * $signed({1'b0, r_s1});
			end
			side_s2 <= side_s1;
		end
		// An arithmetic shift of the product floors it; the sum stays between a and b.
		if (en3) begin
			for (int l = 0; l < LANES; l++) begin
				y_s3[l] <= a_s2[l] + p_s2[l][DATA_W+FRAC_W-1:FRAC_W];
			end
			side_s3 <= side_s2;
		end
	end

	assign out_valid = v_s3;
	assign y         = y_s3;
	assign side_out  = side_s3;

endmodule

@@ verif/tgi_tb_pkg.sv @@
`timescale 1ns / 1ps
package tgi_tb_pkg;
	import tgi_pkg::*;

	localparam int unsigned SIDE  = DEF_GRID_SIDE;
	localparam int unsigned STEPS = DEF_TIME_STEPS;
	localparam int unsigned DEPTH = SIDE * SIDE * STEPS;

	typedef struct {
		int unsigned lo;
		int unsigned hi;
		int unsigned frac;
		bit          oor;
	} axis_pos_t;

	function automatic int unsigned cell_addr(int unsigned x, int unsigned y, int unsigned t);
		return (x * SIDE + y) * STEPS + t;
	endfunction

	// Splits an axis offset into low corner, high corner and Q0.16 fraction.
	function automatic axis_pos_t locate_axis(longint offset, bit [31:0] inv, int unsigned n);
		axis_pos_t a;
		bit [63:0] d;
		bit [63:0] pos;
		a.lo = 0;
		a.frac = 0;
		a.oor = 0;
		if (offset < 0) begin
			a.oor = 1;
		end else begin
			d = offset;
			pos = d * inv[31:16] + ((d * inv[15:0]) >> 16);
			if (pos[63:16] > n - 1) begin
				a.lo = n - 1;
				a.oor = 1;
			end else begin
				a.lo = pos[47:16];
				a.frac = pos[15:0];
			end
		end
		a.hi = (a.lo == n - 1) ? a.lo : a.lo + 1;
		return a;
	endfunction

endpackage

@@ verif/tgi_checker.sv @@
`timescale 1ns / 1ps
module tgi_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	tgi_in_if                     in_mon,
	tgi_out_if                    out_mon,
	output int                    errors,
	output int                    pending
);
	import tgi_pkg::*;
	import tgi_tb_pkg::*;

	typedef struct {
		logic [31:0] value;
		logic        oor;
	} result_t;

	int          grid [DEPTH];
	int          origin_reg;
	bit [31:0]   inv_spacing_reg;
	bit [31:0]   inv_step_reg;
	result_t     expected_q[$];

	initial begin
		errors = 0;
		pending = 0;
	end

	task automatic report_mismatch(string msg);
		$display("check: %s at %0t", msg, $realtime);
		errors++;
	endtask

	function automatic int blend(int a, int b, int unsigned r);
		longint p;
		p = (longint'(b) - longint'(a)) * longint'(r);
		return int'(longint'(a) + (p >>> 16));
	endfunction

	function automatic result_t interpolate(int x, int y, int t);
		axis_pos_t ax, ay, at;
		int u1, u2, u3, u4, u5, u6;
		result_t r;
		ax = locate_axis(longint'(x) - longint'(origin_reg), inv_spacing_reg, SIDE);
		ay = locate_axis(longint'(y) - longint'(origin_reg), inv_spacing_reg, SIDE);
		at = locate_axis(longint'(t), inv_step_reg, STEPS);
		u1 = blend(grid[cell_addr(ax.lo, ay.lo, at.lo)], grid[cell_addr(ax.lo, ay.lo, at.hi)], at.frac);
		u2 = blend(grid[cell_addr(ax.hi, ay.lo, at.lo)], grid[cell_addr(ax.hi, ay.lo, at.hi)], at.frac);
		u3 = blend(grid[cell_addr(ax.lo, ay.hi, at.lo)], grid[cell_addr(ax.lo, ay.hi, at.hi)], at.frac);
		u4 = blend(grid[cell_addr(ax.hi, ay.hi, at.lo)], grid[cell_addr(ax.hi, ay.hi, at.hi)], at.frac);
		u5 = blend(u1, u3, ay.frac);
		u6 = blend(u2, u4, ay.frac);
		r.value = blend(u5, u6, ax.frac);
		r.oor = ax.oor | ay.oor | at.oor;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			origin_reg = 0;
			inv_spacing_reg = 32'h10000;
			inv_step_reg = 32'h10000;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_ORIGIN:        origin_reg = cfg_data;
					REG_INV_SPACING:   inv_spacing_reg = cfg_data;
					REG_INV_TIME_STEP: inv_step_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_mon.valid && in_mon.ready) begin
				if (in_mon.command == CMD_WRITE) begin
					grid[cell_addr(in_mon.write_x_index, in_mon.write_y_index,
						in_mon.write_t_index)] = in_mon.write_value;
				end else begin
					expected_q.push_back(interpolate(in_mon.x_coord, in_mon.y_coord,
						in_mon.t_coord));
				end
			end
			if (out_mon.valid && out_mon.ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result with no query waiting");
				end else begin
					want = expected_q.pop_front();
					if (out_mon.value !== want.value)
						report_mismatch($sformatf("value %h, expected %h", out_mon.value,
							want.value));
					if (out_mon.out_of_range !== want.oor)
						report_mismatch($sformatf("out_of_range %b, expected %b",
							out_mon.out_of_range, want.oor));
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
	import tgi_pkg::*;
	import tgi_tb_pkg::*;

	localparam int LIMIT = 3000000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	int          errors;
	int          pending;
	int          cycles;
	bit          quiet;
	bit          written [DEPTH];
	int          cur_origin;
	bit [31:0]   cur_inv_spacing;
	bit [31:0]   cur_inv_step;

	tgi_in_if  in_ch ();
	tgi_out_if out_ch ();

	trilinear_grid_interpolator_unit uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_item(in_ch), .out_item(out_ch)
	);

	tgi_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_mon(in_ch), .out_mon(out_ch),
		.errors(errors), .pending(pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		out_ch.ready = 1'b1;
		@(negedge arst_n or posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ch.ready = 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end
			out_ch.ready = 1'b1;
			repeat ($urandom_range(1, 20)) @(negedge clk);
		end
	end

	task automatic send_item(logic cmd, int x, int y, int t, int wx, int wy, int wt, int wv);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_ch.command = cmd;
		in_ch.x_coord = x;
		in_ch.y_coord = y;
		in_ch.t_coord = t;
		in_ch.write_x_index = wx;
		in_ch.write_y_index = wy;
		in_ch.write_t_index = wt;
		in_ch.write_value = wv;
		in_ch.valid = 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	function automatic int grid_word();
		case ($urandom_range(0, 9))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 0;
			default: return $urandom;
		endcase
	endfunction

	task automatic write_cell(int x, int y, int t, int v);
		written[cell_addr(x, y, t)] = 1'b1;
		send_item(CMD_WRITE, $urandom, $urandom, $urandom, x, y, t, v);
	endtask

	// The eight corners a query reads are loaded first if they never were.
	task automatic query(int x, int y, int t);
		axis_pos_t ax, ay, at;
		int unsigned cx, cy, ct;
		ax = locate_axis(longint'(x) - longint'(cur_origin), cur_inv_spacing, SIDE);
		ay = locate_axis(longint'(y) - longint'(cur_origin), cur_inv_spacing, SIDE);
		at = locate_axis(longint'(t), cur_inv_step, STEPS);
		for (int i = 0; i < 8; i++) begin
			cx = i[0] ? ax.hi : ax.lo;
			cy = i[1] ? ay.hi : ay.lo;
			ct = i[2] ? at.hi : at.lo;
			if (!written[cell_addr(cx, cy, ct)])
				write_cell(cx, cy, ct, grid_word());
		end
		send_item(CMD_QUERY, x, y, t, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic set_reg(cfg_reg_t r, bit [31:0] v);
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = r;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
		case (r)
			REG_ORIGIN:        cur_origin = v;
			REG_INV_SPACING:   cur_inv_spacing = v;
			REG_INV_TIME_STEP: cur_inv_step = v;
			default: ;
		endcase
	endtask

	function automatic int near_coord(int base, bit [31:0] inv);
		longint span;
		longint c;
		if (inv == 0)
			return $urandom;
		span = (longint'(34) << 32) / inv;
		if (span > 64'h7FFFFFFF)
			span = 64'h7FFFFFFF;
		c = longint'(base) + longint'($urandom_range(0, span)) - span / 16;
		if (c > 64'sh7FFFFFFF)
			c = 64'sh7FFFFFFF;
		if (c < -64'sh80000000)
			c = -64'sh80000000;
		return int'(c);
	endfunction

	task automatic random_items(int n);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 19))
				0, 1, 2:
					write_cell($urandom_range(0, 31), $urandom_range(0, 31),
						$urandom_range(0, 31), grid_word());
				3, 4, 5:
					query($urandom, $urandom, $urandom);
				default:
					query(near_coord(cur_origin, cur_inv_spacing),
						near_coord(cur_origin, cur_inv_spacing), near_coord(0, cur_inv_step));
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cycles = 0;
		quiet = 1'b0;
		cur_origin = 0;
		cur_inv_spacing = 32'h10000;
		cur_inv_step = 32'h10000;
		in_ch.valid = 1'b0;
		in_ch.command = CMD_WRITE;
		in_ch.x_coord = '0;
		in_ch.y_coord = '0;
		in_ch.t_coord = '0;
		in_ch.write_x_index = '0;
		in_ch.write_y_index = '0;
		in_ch.write_t_index = '0;
		in_ch.write_value = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_cell(0, 0, 0, 32'h7FFFFFFF);
		write_cell(0, 0, 1, 32'h80000000);
		write_cell(1, 0, 0, 32'h80000000);
		write_cell(0, 1, 0, 32'h7FFFFFFF);
		write_cell(31, 31, 31, -1);
		query(0, 0, 32'h8000);
		query(32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF);
		query(32'hFFFFFFFF, 0, 0);
		query(0, 32'h80000000, 0);
		query(0, 0, 32'hFFFF0000);
		query(31 << 16, 31 << 16, 31 << 16);
		query(32'h001F8000, 32'h00108000, 32'h001F4000);
		query(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		query(32'h00208000, 5 << 16, 3 << 16);

		random_items(35);
		set_reg(REG_ORIGIN, 32'h80000000);
		set_reg(REG_INV_SPACING, 32'h10000);
		set_reg(REG_INV_TIME_STEP, 32'h20000);
		random_items(35);
		set_reg(REG_ORIGIN, 32'h7FFFFFFF);
		set_reg(REG_INV_SPACING, 32'h0);
		set_reg(REG_INV_TIME_STEP, 32'hFFFFFFFF);
		random_items(25);
		set_reg(REG_ORIGIN, 32'hFFFD0000);
		set_reg(REG_INV_SPACING, 32'hFFFFFFFF);
		set_reg(REG_INV_TIME_STEP, 32'h0);
		random_items(25);
		set_reg(REG_ORIGIN, 32'hFFF80000);
		set_reg(REG_INV_SPACING, 32'h00008000);
		set_reg(REG_INV_TIME_STEP, 32'h00004000);
		random_items(45);
		set_reg(REG_ORIGIN, $urandom);
		set_reg(REG_INV_SPACING, $urandom_range(32'h100, 32'h80000));
		set_reg(REG_INV_TIME_STEP, $urandom_range(32'h100, 32'h80000));
		random_items(45);
		set_reg(REG_ORIGIN, 0);
		set_reg(REG_INV_SPACING, 32'h10000);
		set_reg(REG_INV_TIME_STEP, 32'h10000);
		quiet = 1'b1;
		random_items(40);

		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
